// ===== rtl/bmhq_pkg.sv =====
package bmhq_pkg;

  // Default sizing
  localparam int DEF_CAPACITY = 256;
  localparam int DEF_KEY_BITS = 24;
  localparam int DEF_TAG_BITS = 9;

  // Operation carried on the input tuser
  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  // Result status carried on the output tuser
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// ===== rtl/bmhq_store.sv =====
module bmhq_store #(
  parameter int DEPTH = bmhq_pkg::DEF_CAPACITY,
  parameter int EW    = bmhq_pkg::DEF_KEY_BITS + bmhq_pkg::DEF_TAG_BITS,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [EW-1:0] wr_data,
  input  logic          rd_a_en,
  input  logic [AW-1:0] rd_a_addr,
  output logic [EW-1:0] rd_a_data,
  input  logic          rd_b_en,
  input  logic [AW-1:0] rd_b_addr,
  output logic [EW-1:0] rd_b_data
);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_a_r;
  logic [EW-1:0] rd_b_r;

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_r <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_r <= mem[rd_b_addr];
    end
  end

  assign rd_a_data = rd_a_r;
  assign rd_b_data = rd_b_r;

endmodule

// ===== rtl/bmhq_ctrl.sv =====
module bmhq_ctrl #(
  parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = bmhq_pkg::DEF_KEY_BITS,
  parameter int TAG_BITS = bmhq_pkg::DEF_TAG_BITS,
  localparam int AW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1),
  localparam int EW      = KEY_BITS + TAG_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  // request side
  input  logic                in_valid,
  output logic                in_ready,
  input  bmhq_pkg::op_t       in_op,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic [TAG_BITS-1:0] in_tag,
  // result side
  output logic                res_valid,
  input  logic                res_ready,
  output logic [KEY_BITS-1:0] res_key,
  output logic [TAG_BITS-1:0] res_tag,
  output bmhq_pkg::status_t   res_status,
  output logic [CW-1:0]       res_count,
  // heap memory
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [EW-1:0]       wr_data,
  output logic                rd_a_en,
  output logic [AW-1:0]       rd_a_addr,
  input  logic [EW-1:0]       rd_a_data,
  output logic                rd_b_en,
  output logic [AW-1:0]       rd_b_addr,
  input  logic [EW-1:0]       rd_b_data
);

  localparam int IW = AW + 2;  // child index may reach 2*CAPACITY

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_EX_LD,
    S_DN_RD,
    S_DN_CMP,
    S_RESP
  } state_t;

  state_t               state_r, state_nxt;
  logic [KEY_BITS-1:0]  cur_key_r, cur_key_nxt;
  logic [TAG_BITS-1:0]  cur_tag_r, cur_tag_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [KEY_BITS-1:0]  res_key_r, res_key_nxt;
  logic [TAG_BITS-1:0]  res_tag_r, res_tag_nxt;
  bmhq_pkg::status_t    res_status_r, res_status_nxt;

  logic                 in_fire;
  logic                 is_full;
  logic [AW-1:0]        par_idx;
  logic [IW-1:0]        lc_idx;
  logic [IW-1:0]        rc_idx;
  logic                 lc_ok;
  logic                 rc_ok;
  logic [KEY_BITS-1:0]  a_key;
  logic [KEY_BITS-1:0]  b_key;
  logic [KEY_BITS-1:0]  best_key;
  logic                 take_l;
  logic                 take_r;
  logic [EW-1:0]        cur_entry;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_full   = (cnt_r == CW'(CAPACITY));

  // tree navigation around the hole position
  assign par_idx   = (pos_r - AW'(1)) >> 1;
  assign lc_idx    = {1'b0, pos_r, 1'b1};
  assign rc_idx    = lc_idx + IW'(1);
  assign lc_ok     = lc_idx < IW'(cnt_r);
  assign rc_ok     = rc_idx < IW'(cnt_r);

  // entries are packed key over tag
  assign a_key     = rd_a_data[EW-1:TAG_BITS];
  assign b_key     = rd_b_data[EW-1:TAG_BITS];
  assign cur_entry = {cur_key_r, cur_tag_r};

  // sift-down pick: left wins on strict less, right on strict less than that
  assign take_l    = a_key < cur_key_r;
  assign best_key  = take_l ? a_key : cur_key_r;
  assign take_r    = rc_ok && (b_key < best_key);

  // memory addressing
  always_comb begin
    rd_a_en   = 1'b0;
    rd_b_en   = 1'b0;
    rd_a_addr = '0;
    rd_b_addr = AW'(cnt_r - CW'(1));
    wr_addr   = pos_r;
    unique case (state_r)
      S_IDLE: begin
        // root and last entry for an extract
        rd_a_en = in_fire && (in_op == bmhq_pkg::OP_EXTRACT) && (cnt_r != '0);
        rd_b_en = rd_a_en;
      end
      S_UP_RD: begin
        rd_a_en   = (pos_r != '0);
        rd_a_addr = par_idx;
      end
      S_DN_RD: begin
        rd_a_en   = lc_ok;
        rd_a_addr = lc_idx[AW-1:0];
        rd_b_en   = rc_ok;
        rd_b_addr = rc_idx[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    cur_key_nxt    = cur_key_r;
    cur_tag_nxt    = cur_tag_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    res_key_nxt    = res_key_r;
    res_tag_nxt    = res_tag_r;
    res_status_nxt = res_status_r;
    wr_en          = 1'b0;
    wr_data        = cur_entry;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_key_nxt    = '0;
          res_tag_nxt    = '0;
          res_status_nxt = bmhq_pkg::ST_OK;
          if (in_op == bmhq_pkg::OP_INSERT) begin
            if (is_full) begin
              res_status_nxt = bmhq_pkg::ST_FULL;
              state_nxt      = S_RESP;
            end else begin
              cur_key_nxt = in_key;
              cur_tag_nxt = in_tag;
              pos_nxt     = cnt_r[AW-1:0];
              cnt_nxt     = cnt_r + CW'(1);
              state_nxt   = S_UP_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              res_status_nxt = bmhq_pkg::ST_EMPTY;
              state_nxt      = S_RESP;
            end else begin
              cnt_nxt   = cnt_r - CW'(1);
              state_nxt = S_EX_LD;
            end
          end
        end
      end
      S_UP_RD: begin
        // at the root the climb ends
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (a_key > cur_key_r) begin
          // parent moves down into the hole
          wr_en     = 1'b1;
          wr_data   = rd_a_data;
          pos_nxt   = par_idx;
          state_nxt = S_UP_RD;
        end else begin
          wr_en     = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_EX_LD: begin
        res_key_nxt = a_key;
        res_tag_nxt = rd_a_data[TAG_BITS-1:0];
        if (cnt_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          cur_key_nxt = b_key;
          cur_tag_nxt = rd_b_data[TAG_BITS-1:0];
          pos_nxt     = '0;
          state_nxt   = S_DN_RD;
        end
      end
      S_DN_RD: begin
        // leaf reached: drop the moving entry here
        if (!lc_ok) begin
          wr_en     = 1'b1;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (take_r) begin
          wr_en     = 1'b1;
          wr_data   = rd_b_data;
          pos_nxt   = rc_idx[AW-1:0];
          state_nxt = S_DN_RD;
        end else if (take_l) begin
          wr_en     = 1'b1;
          wr_data   = rd_a_data;
          pos_nxt   = lc_idx[AW-1:0];
          state_nxt = S_DN_RD;
        end else begin
          wr_en     = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    cur_key_r    <= cur_key_nxt;
    cur_tag_r    <= cur_tag_nxt;
    pos_r        <= pos_nxt;
    res_key_r    <= res_key_nxt;
    res_tag_r    <= res_tag_nxt;
    res_status_r <= res_status_nxt;
  end

  assign res_valid  = (state_r == S_RESP);
  assign res_key    = res_key_r;
  assign res_tag    = res_tag_r;
  assign res_status = res_status_r;
  assign res_count  = cnt_r;

`ifndef NO_ASSERTIONS
  // a write never shares a cycle with a read, so no forwarding is needed
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && (rd_a_en || rd_b_en)))
    else $error("memory write overlaps a read");

  // the fill count stays within the store
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // a dropped insert leaves the count at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res_status == bmhq_pkg::ST_FULL) |-> is_full)
    else $error("full status with free slots");

  // an accepted beat changes the count by at most one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + CW'(1))
             || (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("count moved by more than one");

  // an empty result carries zero key and tag
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res_status == bmhq_pkg::ST_EMPTY) |-> (res_key == '0) && (res_tag == '0))
    else $error("empty status with nonzero data");
`endif

endmodule

// ===== rtl/binary_min_heap_queue.sv =====
// Channel | Ports              | Beat contents
// in      | in_tvalid/in_tready| tuser: operation; tdata: item_key, item_tag
// out     | out_tvalid/tready  | tuser: status; tdata: out_key, out_tag, entry_count
//
// One operation at a time: a new beat is taken only once the sequencer is idle.
// An insert climbs from the new last slot toward the root; an extract returns
// the root and sinks the last entry down from it. Each level
// costs one read and one compare and write.
// Reset (rst_n low, synchronous) empties the heap; memory contents are not cleared.
// A result waits in the output register; a stalled output holds the sequencer
// in its response step, and the next beat is taken once the result has moved on.
module binary_min_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = bmhq_pkg::DEF_KEY_BITS,
  parameter int TAG_BITS = bmhq_pkg::DEF_TAG_BITS,
  localparam int AW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1),
  localparam int EW      = KEY_BITS + TAG_BITS,
  localparam int IN_DW   = ((KEY_BITS + TAG_BITS + 7) / 8) * 8,
  localparam int OUT_DW  = ((KEY_BITS + TAG_BITS + CW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // item_key, item_tag, zero pad
  input  logic              in_tuser,   // operation
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // out_key, out_tag, entry_count, zero pad
  output logic [1:0]        out_tuser   // status
);

  logic                 res_valid;
  logic                 res_ready;
  logic [KEY_BITS-1:0]  res_key;
  logic [TAG_BITS-1:0]  res_tag;
  bmhq_pkg::status_t    res_status;
  logic [CW-1:0]        res_count;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [EW-1:0]        wr_data;
  logic                 rd_a_en;
  logic [AW-1:0]        rd_a_addr;
  logic [EW-1:0]        rd_a_data;
  logic                 rd_b_en;
  logic [AW-1:0]        rd_b_addr;
  logic [EW-1:0]        rd_b_data;

  logic                 out_valid_r;
  logic [OUT_DW-1:0]    out_data_r;
  logic [1:0]           out_user_r;

  bmhq_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (bmhq_pkg::op_t'(in_tuser)),
    .in_key     (in_tdata[KEY_BITS-1:0]),
    .in_tag     (in_tdata[KEY_BITS +: TAG_BITS]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_key    (res_key),
    .res_tag    (res_tag),
    .res_status (res_status),
    .res_count  (res_count),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_a_en    (rd_a_en),
    .rd_a_addr  (rd_a_addr),
    .rd_a_data  (rd_a_data),
    .rd_b_en    (rd_b_en),
    .rd_b_addr  (rd_b_addr),
    .rd_b_data  (rd_b_data)
  );

  bmhq_store #(
    .DEPTH (CAPACITY),
    .EW    (EW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_en   (rd_a_en),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_en   (rd_b_en),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  // output register: loads when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_data_r <= OUT_DW'({res_count, res_tag, res_key});
      out_user_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== bench/bmhq_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the heap queue, keeps a mirror of the heap and
// compares every result beat with the oldest predicted one.
module bmhq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,    // item_key, item_tag, zero pad
  input  logic        in_tuser,    // operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,   // out_key, out_tag, entry_count, zero pad
  input  logic [1:0]  out_tuser,   // status
  output int          mismatch_count,
  output int          open_results
);

  localparam int KEY_W = bmhq_pkg::DEF_KEY_BITS;
  localparam int TAG_W = bmhq_pkg::DEF_TAG_BITS;
  localparam int DEPTH = bmhq_pkg::DEF_CAPACITY;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    bmhq_pkg::status_t status;
    logic [8:0]        count;
  } heap_result_t;

  // Mirror of the heap contents
  logic [KEY_W-1:0] mirror_key [DEPTH];
  logic [TAG_W-1:0] mirror_tag [DEPTH];
  int unsigned      mirror_count = 0;

  heap_result_t result_fifo [$];
  int           errors = 0;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    k = mirror_key[a];
    t = mirror_tag[a];
    mirror_key[a] = mirror_key[b];
    mirror_tag[a] = mirror_tag[b];
    mirror_key[b] = k;
    mirror_tag[b] = t;
  endfunction

  // Apply one operation to the mirror and return the result it must produce
  function automatic heap_result_t apply_heap_op(bmhq_pkg::op_t op, logic [KEY_W-1:0] k,
                                                 logic [TAG_W-1:0] t);
    heap_result_t r;
    int unsigned  pos;
    int unsigned  up;
    int unsigned  best;
    int unsigned  lc;
    int unsigned  rc;
    bit           done;
    r = '{key: '0, tag: '0, status: bmhq_pkg::ST_OK, count: '0};
    if (op == bmhq_pkg::OP_INSERT) begin
      if (mirror_count >= DEPTH) begin
        r.status = bmhq_pkg::ST_FULL;
      end else begin
        pos = mirror_count;
        mirror_key[pos] = k;
        mirror_tag[pos] = t;
        mirror_count++;
        // sift up while the parent is strictly greater
        done = 1'b0;
        while (pos > 0 && !done) begin
          up = (pos - 1) / 2;
          if (mirror_key[up] > mirror_key[pos]) begin
            swap_slots(up, pos);
            pos = up;
          end else begin
            done = 1'b1;
          end
        end
      end
    end else begin
      if (mirror_count == 0) begin
        r.status = bmhq_pkg::ST_EMPTY;
      end else begin
        r.key = mirror_key[0];
        r.tag = mirror_tag[0];
        mirror_count--;
        if (mirror_count > 0) begin
          mirror_key[0] = mirror_key[mirror_count];
          mirror_tag[0] = mirror_tag[mirror_count];
          // sift down: left child first, right only if strictly smaller still
          pos = 0;
          done = 1'b0;
          while (!done) begin
            best = pos;
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc < mirror_count && mirror_key[lc] < mirror_key[best]) best = lc;
            if (rc < mirror_count && mirror_key[rc] < mirror_key[best]) best = rc;
            if (best == pos) begin
              done = 1'b1;
            end else begin
              swap_slots(best, pos);
              pos = best;
            end
          end
        end
      end
    end
    r.count = mirror_count[8:0];
    return r;
  endfunction

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Input beats feed the mirror, result beats are checked in order
  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        result_fifo.push_back(apply_heap_op(bmhq_pkg::op_t'(in_tuser), in_tdata[23:0],
                                            in_tdata[32:24]));
      if (out_tvalid && out_tready) begin
        if (result_fifo.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual key %0h tag %0h",
                   $time, out_tdata[23:0], out_tdata[32:24]);
          errors++;
        end else begin
          want = result_fifo.pop_front();
          compare_field("out_key", want.key, out_tdata[23:0]);
          compare_field("out_tag", want.tag, out_tdata[32:24]);
          compare_field("status", want.status, out_tuser);
          compare_field("entry_count", want.count, out_tdata[41:33]);
        end
      end
    end
    mismatch_count <= errors;
    open_results   <= result_fifo.size();
  end

endmodule

// ===== bench/tb_binary_min_heap_queue.sv =====
`timescale 1ns / 1ps

module tb_binary_min_heap_queue;

  localparam int DEPTH          = bmhq_pkg::DEF_CAPACITY;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // item_key, item_tag, zero pad
  logic        in_tuser;    // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;   // out_key, out_tag, entry_count, zero pad
  logic [1:0]  out_tuser;   // status

  int mismatch_count;
  int open_results;

  bit idle_on  = 1'b1;
  bit hold_out = 1'b0;
  int depth_guess = 0;
  int stall_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  binary_min_heap_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  bmhq_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .mismatch_count(mismatch_count),
    .open_results  (open_results)
  );

  // Keys lean toward extremes and a narrow band so ties show up often
  function automatic logic [23:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2, 3: return 24'($urandom_range(0, 7));
      default: return 24'($urandom);
    endcase
  endfunction

  // Offer one beat, with an occasional gap in front of it
  task automatic send_beat(bmhq_pkg::op_t op, logic [23:0] k, logic [8:0] t);
    if (idle_on && $urandom_range(0, 99) < 32) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, t, k};
    do @(posedge clk); while (!in_tready);
    if (op == bmhq_pkg::OP_INSERT && depth_guess < DEPTH) depth_guess++;
    if (op == bmhq_pkg::OP_EXTRACT && depth_guess > 0) depth_guess--;
  endtask

  task automatic run_mixed(int beats, int insert_pct);
    bmhq_pkg::op_t op;
    for (int i = 0; i < beats; i++) begin
      op = ($urandom_range(0, 99) < insert_pct) ? bmhq_pkg::OP_INSERT : bmhq_pkg::OP_EXTRACT;
      send_beat(op, pick_key(), 9'($urandom_range(0, 511)));
    end
  endtask

  // Result side: random backpressure, plus one long hold on request
  initial begin
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        out_tready <= (idle_on && $urandom_range(0, 99) < 32) ? 1'b0 : 1'b1;
      end
    end
  end

  // Watchdog: too long without any beat on either channel
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("tb_binary_min_heap_queue: done, errors");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= bmhq_pkg::OP_INSERT;
    in_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty extracts, key and tag extremes, ties
    send_beat(bmhq_pkg::OP_EXTRACT, 24'h000000, 9'h000);
    send_beat(bmhq_pkg::OP_EXTRACT, 24'hFFFFFF, 9'h1FF);
    send_beat(bmhq_pkg::OP_INSERT, 24'hFFFFFF, 9'h1FF);
    send_beat(bmhq_pkg::OP_INSERT, 24'h000000, 9'h000);
    send_beat(bmhq_pkg::OP_INSERT, 24'h000005, 9'h001);
    send_beat(bmhq_pkg::OP_INSERT, 24'h000005, 9'h002);
    send_beat(bmhq_pkg::OP_INSERT, 24'h000005, 9'h003);
    send_beat(bmhq_pkg::OP_INSERT, 24'hFFFFFF, 9'h000);
    send_beat(bmhq_pkg::OP_INSERT, 24'h000004, 9'h004);
    send_beat(bmhq_pkg::OP_INSERT, 24'h000006, 9'h005);
    repeat (9) send_beat(bmhq_pkg::OP_EXTRACT, 24'h0, 9'h0);

    // Mixed traffic, growing
    run_mixed(300, 60);

    // Fill past capacity while the result side holds off
    hold_out = 1'b1;
    while (depth_guess < DEPTH)
      send_beat(bmhq_pkg::OP_INSERT, pick_key(), 9'($urandom_range(0, 511)));
    repeat (10) send_beat(bmhq_pkg::OP_INSERT, pick_key(), 9'($urandom_range(0, 511)));

    // Drain to empty and beyond
    while (depth_guess > 0)
      send_beat(bmhq_pkg::OP_EXTRACT, 24'($urandom), 9'($urandom_range(0, 511)));
    repeat (6) send_beat(bmhq_pkg::OP_EXTRACT, 24'($urandom), 9'($urandom_range(0, 511)));

    // Balanced traffic, first without any idling
    idle_on = 1'b0;
    run_mixed(200, 50);
    idle_on = 1'b1;
    run_mixed(130, 50);

    in_tvalid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
    repeat (40) @(posedge clk);

    if (mismatch_count == 0)
      $display("tb_binary_min_heap_queue: done, clean");
    else
      $display("tb_binary_min_heap_queue: done, errors");
    $finish;
  end

endmodule
